>>> rtl/core/rwc_pkg.sv
// shared constants, register codes and pipeline types for the wall column setup block
package rwc_pkg;

  // fixed point layout
  localparam int FRACTION_BITS    = 16;
  localparam int TEXTURE_DIM_BITS = 13;
  localparam int DIR_FRAC         = 14;

  // field widths
  localparam int ROW_W      = 12;
  localparam int DIR_W      = 16;
  localparam int POS_W      = 24;
  localparam int LH_W       = 16;
  localparam int FRAC_W     = FRACTION_BITS;
  localparam int COL_W      = TEXTURE_DIM_BITS;
  localparam int STEP_W     = 28;
  localparam int START_W    = 43;
  localparam int OFFS_W     = LH_W - 1;
  localparam int TEX_SIZE_W = 2 * TEXTURE_DIM_BITS;
  localparam int HIT_W      = DIR_FRAC + FRAC_W;

  // stream widths
  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 128;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // divider layout
  localparam int DIV_W          = 32;
  localparam int DIV_BITS_STAGE = 4;
  localparam int DIV_STAGES     = DIV_W / DIV_BITS_STAGE;

  localparam logic [STEP_W-1:0]     STEP_MAX          = '1;
  localparam logic [ROW_W-1:0]      WINDOW_HEIGHT_RST = 12'd480;
  localparam logic [TEX_SIZE_W-1:0] TEX_SIZE_RST      = 26'd524352;

  localparam logic SIDE_X = 1'b0;
  localparam logic SIDE_Y = 1'b1;

  typedef enum logic [1:0] {
    FACE_DEFAULT = 2'd0,
    FACE_Y_NEG   = 2'd1,
    FACE_X_POS   = 2'd2,
    FACE_X_NEG   = 2'd3
  } face_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_HEIGHT = 3'd0,
    REG_NORTH_SIZE    = 3'd1,
    REG_SOUTH_SIZE    = 3'd2,
    REG_WEST_SIZE     = 3'd3,
    REG_EAST_SIZE     = 3'd4
  } cfg_reg_t;

  typedef logic [TEX_SIZE_W-1:0] tex_size_t;

  typedef struct packed {
    logic [ROW_W-1:0] window_height;
    tex_size_t [3:0]  tex_size;
  } cfg_t;

  // per column fields that ride alongside the divider
  typedef struct packed {
    logic [ROW_W-1:0]  top_row;
    logic [ROW_W-1:0]  bottom_row;
    logic [FRAC_W-1:0] wall_fraction;
    logic [COL_W-1:0]  texture_column;
    logic [1:0]        face_index;
    logic [OFFS_W-1:0] row_offset;
  } col_side_t;

  typedef struct packed {
    col_side_t         side;
    logic [LH_W-1:0]   divisor;
    logic [LH_W-1:0]   rem;
    logic [DIV_W-1:0]  word;
  } div_data_t;

  typedef struct packed {
    logic [1:0]         face_index;
    logic [START_W-1:0] texture_start;
    logic [STEP_W-1:0]  texture_step;
    logic [COL_W-1:0]   texture_column;
    logic [FRAC_W-1:0]  wall_fraction;
    logic [ROW_W-1:0]   bottom_row;
    logic [ROW_W-1:0]   top_row;
  } result_t;

endpackage

>>> rtl/core/rwc_cfg_regs.sv
// configuration register file behind the apb-style port
module rwc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rwc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rwc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rwc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output rwc_pkg::cfg_t                    cfg
);

  rwc_pkg::cfg_t     cfg_r;
  rwc_pkg::cfg_reg_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = rwc_pkg::cfg_reg_t'(paddr[rwc_pkg::CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_height <= rwc_pkg::WINDOW_HEIGHT_RST;
      cfg_r.tex_size[0]   <= rwc_pkg::TEX_SIZE_RST;
      cfg_r.tex_size[1]   <= rwc_pkg::TEX_SIZE_RST;
      cfg_r.tex_size[2]   <= rwc_pkg::TEX_SIZE_RST;
      cfg_r.tex_size[3]   <= rwc_pkg::TEX_SIZE_RST;
    end else if (wr_en) begin
      case (idx)
        rwc_pkg::REG_WINDOW_HEIGHT:
          cfg_r.window_height <= pwdata[rwc_pkg::ROW_W-1:0];
        rwc_pkg::REG_NORTH_SIZE: cfg_r.tex_size[0] <= pwdata[rwc_pkg::TEX_SIZE_W-1:0];
        rwc_pkg::REG_SOUTH_SIZE: cfg_r.tex_size[1] <= pwdata[rwc_pkg::TEX_SIZE_W-1:0];
        rwc_pkg::REG_WEST_SIZE:  cfg_r.tex_size[2] <= pwdata[rwc_pkg::TEX_SIZE_W-1:0];
        rwc_pkg::REG_EAST_SIZE:  cfg_r.tex_size[3] <= pwdata[rwc_pkg::TEX_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rwc_pkg::REG_WINDOW_HEIGHT:
        prdata = rwc_pkg::CFG_DATA_W'(cfg_r.window_height);
      rwc_pkg::REG_NORTH_SIZE: prdata = rwc_pkg::CFG_DATA_W'(cfg_r.tex_size[0]);
      rwc_pkg::REG_SOUTH_SIZE: prdata = rwc_pkg::CFG_DATA_W'(cfg_r.tex_size[1]);
      rwc_pkg::REG_WEST_SIZE:  prdata = rwc_pkg::CFG_DATA_W'(cfg_r.tex_size[2]);
      rwc_pkg::REG_EAST_SIZE:  prdata = rwc_pkg::CFG_DATA_W'(cfg_r.tex_size[3]);
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/rwc_front.sv
// front stages: row clamping, wall hit fraction, face and texture column
module rwc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rwc_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             hit_side,
  input  logic signed [rwc_pkg::DIR_W-1:0] dir_x,
  input  logic signed [rwc_pkg::DIR_W-1:0] dir_y,
  input  logic [rwc_pkg::POS_W-1:0]        perp_distance,
  input  logic [rwc_pkg::POS_W-1:0]        player_x,
  input  logic [rwc_pkg::POS_W-1:0]        player_y,
  input  logic [rwc_pkg::LH_W-1:0]         slice_rows,
  input  logic [1:0]                       texture_select,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rwc_pkg::div_data_t               out_data
);

  localparam int PROD_W = rwc_pkg::POS_W + 1 + rwc_pkg::DIR_W;
  localparam int CPROD_W = rwc_pkg::FRAC_W + rwc_pkg::COL_W;

  // stage 1 combinational
  logic [rwc_pkg::ROW_W-2:0]         half_wy;
  logic [rwc_pkg::LH_W-2:0]          half_lh;
  logic signed [rwc_pkg::LH_W:0]     start_diff;
  logic [rwc_pkg::LH_W:0]            start_neg_diff;
  logic                              start_neg;
  logic                              start_clamp;
  logic [rwc_pkg::LH_W-1:0]          end_sum;
  logic [rwc_pkg::POS_W-1:0]         hit_pos;
  logic signed [rwc_pkg::DIR_W-1:0]  hit_dir;
  logic signed [PROD_W-1:0]          hit_prod;
  logic [rwc_pkg::HIT_W-1:0]         hit_sum;
  rwc_pkg::tex_size_t                tsize;
  rwc_pkg::face_t                    face;

  logic [rwc_pkg::ROW_W-1:0]         start_nxt, end_nxt;
  logic [rwc_pkg::FRAC_W-1:0]        frac_nxt;
  logic [rwc_pkg::OFFS_W-1:0]        offs_nxt;
  logic                              mirror_nxt;

  // stage 1 registers
  logic                              s1_valid_r;
  logic [rwc_pkg::ROW_W-1:0]         s1_start_r, s1_end_r;
  logic [rwc_pkg::FRAC_W-1:0]        s1_frac_r;
  logic [1:0]                        s1_face_r;
  logic                              s1_mirror_r;
  logic [rwc_pkg::COL_W-1:0]         s1_width_r;
  logic [rwc_pkg::COL_W-1:0]         s1_height_r;
  logic [rwc_pkg::LH_W-1:0]          s1_lh_r;
  logic [rwc_pkg::OFFS_W-1:0]        s1_offs_r;
  logic                              s1_ready;

  // stage 2
  logic [CPROD_W-1:0]                col_prod;
  logic [rwc_pkg::COL_W-1:0]         col_raw;
  rwc_pkg::div_data_t                s2_nxt;
  rwc_pkg::div_data_t                s2_data_r;
  logic                              s2_valid_r;
  logic                              s2_ready;

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    half_wy        = cfg.window_height[rwc_pkg::ROW_W-1:1];
    half_lh        = slice_rows[rwc_pkg::LH_W-1:1];
    start_diff     = $signed({6'b0, half_wy}) - $signed({2'b0, half_lh});
    start_neg_diff = (rwc_pkg::LH_W+1)'(0) - start_diff;
    start_neg      = start_diff[rwc_pkg::LH_W];
    start_clamp    = start_neg ||
                     (start_diff[rwc_pkg::LH_W-1:0] > {4'b0, cfg.window_height});
    start_nxt      = start_clamp ? '0 : start_diff[rwc_pkg::ROW_W-1:0];
    // texture offset is nonzero only when the slice runs off the top
    offs_nxt       = start_neg ? start_neg_diff[rwc_pkg::OFFS_W-1:0] : '0;

    end_sum = {1'b0, half_lh} + {5'b0, half_wy};
    end_nxt = (end_sum >= {4'b0, cfg.window_height}) ? cfg.window_height - 12'd1
                                                     : end_sum[rwc_pkg::ROW_W-1:0];

    // hit coordinate along the wall
    hit_pos  = (hit_side == rwc_pkg::SIDE_X) ? player_y : player_x;
    hit_dir  = (hit_side == rwc_pkg::SIDE_X) ? dir_y : dir_x;
    hit_prod = PROD_W'($signed({1'b0, perp_distance})) * PROD_W'(hit_dir);
    hit_sum  = {hit_pos[rwc_pkg::FRAC_W-1:0], {rwc_pkg::DIR_FRAC{1'b0}}} +
               hit_prod[rwc_pkg::HIT_W-1:0];
    frac_nxt = hit_sum[rwc_pkg::HIT_W-1:rwc_pkg::DIR_FRAC];

    tsize = cfg.tex_size[texture_select];

    mirror_nxt = ((hit_side == rwc_pkg::SIDE_X) && (dir_x > 0)) ||
                 ((hit_side == rwc_pkg::SIDE_Y) && (dir_y < 0));

    if (hit_side == rwc_pkg::SIDE_X) begin
      if (dir_x < 0) begin
        face = rwc_pkg::FACE_X_NEG;
      end else if (dir_x > 0) begin
        face = rwc_pkg::FACE_X_POS;
      end else begin
        face = rwc_pkg::FACE_DEFAULT;
      end
    end else begin
      face = (dir_y < 0) ? rwc_pkg::FACE_Y_NEG : rwc_pkg::FACE_DEFAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_start_r  <= start_nxt;
      s1_end_r    <= end_nxt;
      s1_frac_r   <= frac_nxt;
      s1_face_r   <= face;
      s1_mirror_r <= mirror_nxt;
      s1_width_r  <= tsize[rwc_pkg::TEXTURE_DIM_BITS-1:0];
      s1_height_r <= tsize[rwc_pkg::TEX_SIZE_W-1:rwc_pkg::TEXTURE_DIM_BITS];
      s1_lh_r     <= slice_rows;
      s1_offs_r   <= offs_nxt;
    end
  end

  // texture column with mirror flip, then seed the divider
  always_comb begin
    col_prod = CPROD_W'(s1_frac_r) * CPROD_W'(s1_width_r);
    col_raw  = col_prod[CPROD_W-1:rwc_pkg::FRACTION_BITS];
    s2_nxt.side.top_row        = s1_start_r;
    s2_nxt.side.bottom_row     = s1_end_r;
    s2_nxt.side.wall_fraction  = s1_frac_r;
    s2_nxt.side.texture_column = s1_mirror_r ? (s1_width_r - col_raw - 13'd1) : col_raw;
    s2_nxt.side.face_index     = s1_face_r;
    s2_nxt.side.row_offset     = s1_offs_r;
    s2_nxt.divisor             = s1_lh_r;
    s2_nxt.rem                 = '0;
    s2_nxt.word = rwc_pkg::DIV_W'({s1_height_r, {rwc_pkg::FRACTION_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_data_r <= s2_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_data  = s2_data_r;

endmodule

>>> rtl/core/rwc_div_stage.sv
// one stage of the pipelined restoring divider, a few quotient bits per stage
module rwc_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rwc_pkg::div_data_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rwc_pkg::div_data_t out_data
);

  logic [rwc_pkg::LH_W-1:0]  rem;
  logic [rwc_pkg::LH_W:0]    trial;
  logic [rwc_pkg::DIV_W-1:0] word;
  rwc_pkg::div_data_t        data_nxt;
  rwc_pkg::div_data_t        data_r;
  logic                      valid_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    rem  = in_data.rem;
    word = in_data.word;
    for (int i = 0; i < rwc_pkg::DIV_BITS_STAGE; i++) begin
      trial = {rem, word[rwc_pkg::DIV_W-1]};
      word  = {word[rwc_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, in_data.divisor}) begin
        trial   = trial - {1'b0, in_data.divisor};
        word[0] = 1'b1;
      end
      rem = trial[rwc_pkg::LH_W-1:0];
    end
    data_nxt      = in_data;
    data_nxt.rem  = rem;
    data_nxt.word = word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> rtl/core/rwc_tail.sv
// step saturation, starting texture row and the output register
module rwc_tail (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rwc_pkg::div_data_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rwc_pkg::result_t   out_result
);

  logic [rwc_pkg::STEP_W-1:0]  step;
  logic [rwc_pkg::START_W-1:0] tstart;
  rwc_pkg::result_t            result_nxt;
  rwc_pkg::result_t            result_r;
  logic                        valid_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    // zero divisor leaves an all-ones quotient, so it saturates here too
    step   = (|in_data.word[rwc_pkg::DIV_W-1:rwc_pkg::STEP_W]) ? rwc_pkg::STEP_MAX
                                                               : in_data.word[rwc_pkg::STEP_W-1:0];
    tstart = rwc_pkg::START_W'(in_data.side.row_offset) * rwc_pkg::START_W'(step);
    result_nxt.face_index     = in_data.side.face_index;
    result_nxt.texture_start  = tstart;
    result_nxt.texture_step   = step;
    result_nxt.texture_column = in_data.side.texture_column;
    result_nxt.wall_fraction  = in_data.side.wall_fraction;
    result_nxt.bottom_row     = in_data.side.bottom_row;
    result_nxt.top_row        = in_data.side.top_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

>>> rtl/core/raycast_wall_column_texture_setup_top.sv
// top level of the textured wall column setup pipeline
// depth: 2 front, 8 divider and 1 tail register stages; every stage has its own valid bit
// throughput: one column per cycle while out_tready is high; every stage has skid-free ready
// the 8-stage divider (4 quotient bits per stage) for texture_step sets the depth
// reset: rst_n synchronous active low clears all valid bits and loads register defaults
// (window height 480, all four textures 64x64); no memory clearing pass
module raycast_wall_column_texture_setup_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // dir_x[15:0], dir_y[31:16], perp_distance[55:32], player_x[79:56],
  // player_y[103:80], slice rows[119:104]
  input  logic [rwc_pkg::IN_DATA_W-1:0]      in_tdata,
  // hit_side[0], texture_select[2:1]
  input  logic [rwc_pkg::IN_USER_W-1:0]      in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // top row[11:0], bottom row[23:12], wall_fraction[39:24], texture_column[52:40],
  // texture_step[80:53], texture_start[123:81], face_index[125:124], zero pad above
  output logic [rwc_pkg::OUT_DATA_W-1:0]     out_tdata,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rwc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [rwc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [rwc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  rwc_pkg::cfg_t              cfg;
  logic [rwc_pkg::DIV_STAGES:0] div_valid;
  logic [rwc_pkg::DIV_STAGES:0] div_ready;
  rwc_pkg::div_data_t         div_data [rwc_pkg::DIV_STAGES+1];
  rwc_pkg::result_t           result;

  // register file
  rwc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // rows, hit fraction, face, texture column; seeds the divider
  rwc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .hit_side       (in_tuser[0]),
    .dir_x          (in_tdata[15:0]),
    .dir_y          (in_tdata[31:16]),
    .perp_distance  (in_tdata[55:32]),
    .player_x       (in_tdata[79:56]),
    .player_y       (in_tdata[103:80]),
    .slice_rows     (in_tdata[119:104]),
    .texture_select (in_tuser[2:1]),
    .out_valid      (div_valid[0]),
    .out_ready      (div_ready[0]),
    .out_data       (div_data[0])
  );

  // (height << 16) / slice rows, column fields ride along
  for (genvar g = 0; g < rwc_pkg::DIV_STAGES; g++) begin : g_div
    rwc_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_valid[g]),
      .in_ready  (div_ready[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_ready (div_ready[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  // saturate step, starting texture row, output register
  rwc_tail u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (div_valid[rwc_pkg::DIV_STAGES]),
    .in_ready   (div_ready[rwc_pkg::DIV_STAGES]),
    .in_data    (div_data[rwc_pkg::DIV_STAGES]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  assign out_tdata = {2'b0, result};

`ifndef NO_ASSERTIONS
  // a zero slice height must come out of the divider as an all-ones quotient
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (div_valid[rwc_pkg::DIV_STAGES] && (div_data[rwc_pkg::DIV_STAGES].divisor == '0))
      |-> (&div_data[rwc_pkg::DIV_STAGES].word))
    else $error("divider: zero divisor did not saturate");

  // a nonzero starting texture row only happens when the slice is clipped at the top
  a_start_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (result.texture_start != '0)) |-> (result.top_row == '0))
    else $error("texture start set on an unclipped slice");

  // clamped rows keep their order
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (result.top_row <= result.bottom_row))
    else $error("top row past bottom row");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
